// ----- rtl/core/rrts_pkg.sv -----
// shared types, constants and codes for the round-robin thread scheduler
package rrts_pkg;

  localparam int MAX_THREADS = 8;
  localparam int SLOT_W      = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int DATA_W      = 32;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [DATA_W-1:0]      word_t;
  typedef logic [MAX_THREADS-1:0] mask_t;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_YIELD = 2'd1,
    REQ_SLEEP = 2'd2,
    REQ_ADD   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOREADY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_INC,
    S_WAKE,
    S_DIFF,
    S_CMP,
    S_PARK,
    S_ROT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] period;
    logic [31:0] sleep_ticks;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        switched;
    logic [2:0]  running_thread;
    logic [7:0]  woken_mask;
    logic [31:0] tick_now;
  } out_t;

  // write command into the slot table
  typedef struct packed {
    logic  wr_period;
    logic  wr_last;
    logic  wr_sleep;
    logic  wr_flag;
    slot_t idx;
    logic  flag_val;
    word_t period;
    word_t last;
    word_t sleep;
  } tbl_cmd_t;

endpackage

// ----- rtl/core/rrts_alu.sv -----
// shared 32-bit subtractor with borrow and zero flags
module rrts_alu (
  input  rrts_pkg::word_t a,
  input  rrts_pkg::word_t b,
  output rrts_pkg::word_t diff,
  output logic            borrow,
  output logic            zero
);

  logic [rrts_pkg::DATA_W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[rrts_pkg::DATA_W-1:0];
  assign borrow = full[rrts_pkg::DATA_W];
  assign zero   = (diff == '0);

endmodule

// ----- rtl/core/rrts_slot_table.sv -----
// per-slot storage: period, last-run tick, sleep countdown and sleeping flags
module rrts_slot_table (
  input  logic               clk,
  input  logic               rst_n,
  input  rrts_pkg::tbl_cmd_t cmd,
  input  rrts_pkg::slot_t    rd_idx,
  output rrts_pkg::word_t    rd_period,
  output rrts_pkg::word_t    rd_last,
  output rrts_pkg::word_t    rd_sleep,
  output logic               rd_sleeping
);

  rrts_pkg::word_t period_r [rrts_pkg::MAX_THREADS];
  rrts_pkg::word_t last_r   [rrts_pkg::MAX_THREADS];
  rrts_pkg::word_t sleep_r  [rrts_pkg::MAX_THREADS];
  rrts_pkg::mask_t flag_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_period) begin
      period_r[cmd.idx] <= cmd.period;
    end
    if (cmd.wr_last) begin
      last_r[cmd.idx] <= cmd.last;
    end
    if (cmd.wr_sleep) begin
      sleep_r[cmd.idx] <= cmd.sleep;
    end
  end

  // sleeping flags reset to all ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= '0;
    end else if (cmd.wr_flag) begin
      flag_r[cmd.idx] <= cmd.flag_val;
    end
  end

  assign rd_period   = period_r[rd_idx];
  assign rd_last     = last_r[rd_idx];
  assign rd_sleep    = sleep_r[rd_idx];
  assign rd_sleeping = flag_r[rd_idx];

endmodule

// ----- rtl/core/round_robin_thread_scheduler_top.sv -----
// top level: request sequencer, scheduler registers, slot table and shared subtractor
//
// round-robin thread scheduler with sleep timers. a request beat is taken when
// start is high and busy is low; busy then stays high until the single result
// beat has been shown on out_data with out_valid high for exactly one cycle.
// the receiver cannot stall, so the result must be captured in that cycle.
// the arithmetic steps of an item share one 32-bit subtractor, and the
// sequencer steps over the slot table one slot per cycle, so how long an item
// takes depends on the request and on the number of added threads n:
//   add:          writes the next free slot, or reports full
//   tick:         increments the tick, counts down the sleep timers of all n
//                 slots, compares elapsed ticks with the period, rotates if run out
//   yield, sleep: rotation scans at most n slots
//   tick, yield or sleep with no threads: reports empty
// after the result beat the sequencer returns to idle before the next start is taken.
module round_robin_thread_scheduler_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rrts_pkg::in_t  in_data,
  output logic           out_valid,
  output rrts_pkg::out_t out_data
);

  rrts_pkg::state_e state_r, state_nxt;

  // scheduler state
  rrts_pkg::word_t tick_r, tick_nxt;
  rrts_pkg::slot_t cur_r, cur_nxt;
  rrts_pkg::cnt_t  used_r, used_nxt;

  // latched request beat
  rrts_pkg::in_t   req_r, req_nxt;

  // per-item working registers
  rrts_pkg::slot_t idx_r, idx_nxt;       // scan pointer
  rrts_pkg::cnt_t  rot_k_r, rot_k_nxt;   // slots visited by rotation
  rrts_pkg::word_t diff_r, diff_nxt;     // ticks since current slot last ran
  rrts_pkg::mask_t woken_r, woken_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            switched_r, switched_nxt;

  // slot table and shared subtractor hookup
  rrts_pkg::tbl_cmd_t cmd;
  rrts_pkg::slot_t    rd_idx;
  rrts_pkg::word_t    rd_period, rd_last, rd_sleep;
  logic               rd_sleeping;
  rrts_pkg::word_t    alu_a, alu_b, alu_diff;
  logic               alu_borrow, alu_zero;

  // cyclic step of the scan pointer among used slots
  logic            idx_last;
  rrts_pkg::slot_t idx_step;
  logic            table_full;
  logic            rot_last;

  assign idx_last   = ((rrts_pkg::cnt_t'(idx_r) + rrts_pkg::cnt_t'(1)) == used_r);
  assign idx_step   = idx_last ? '0 : idx_r + rrts_pkg::slot_t'(1);
  assign table_full = (used_r == rrts_pkg::cnt_t'(rrts_pkg::MAX_THREADS));
  assign rot_last   = ((rot_k_r + rrts_pkg::cnt_t'(1)) == used_r);

  rrts_slot_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_idx      (rd_idx),
    .rd_period   (rd_period),
    .rd_last     (rd_last),
    .rd_sleep    (rd_sleep),
    .rd_sleeping (rd_sleeping)
  );

  rrts_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow),
    .zero   (alu_zero)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrts_pkg::S_IDLE: begin
        if (start) begin
          case (in_data.req_type)
            rrts_pkg::REQ_ADD:  state_nxt = rrts_pkg::S_ADD;
            rrts_pkg::REQ_TICK: state_nxt = rrts_pkg::S_INC;
            default:            state_nxt = rrts_pkg::S_PARK;
          endcase
        end
      end
      rrts_pkg::S_ADD: state_nxt = rrts_pkg::S_DONE;
      rrts_pkg::S_INC: begin
        state_nxt = (used_r == '0) ? rrts_pkg::S_DONE : rrts_pkg::S_WAKE;
      end
      rrts_pkg::S_WAKE: begin
        if (idx_last) begin
          state_nxt = rrts_pkg::S_DIFF;
        end
      end
      rrts_pkg::S_DIFF: state_nxt = rrts_pkg::S_CMP;
      rrts_pkg::S_CMP: begin
        // slice ran out when period <= elapsed
        state_nxt = alu_borrow ? rrts_pkg::S_DONE : rrts_pkg::S_ROT;
      end
      rrts_pkg::S_PARK: begin
        state_nxt = (used_r == '0) ? rrts_pkg::S_DONE : rrts_pkg::S_ROT;
      end
      rrts_pkg::S_ROT: begin
        if (!rd_sleeping || rot_last) begin
          state_nxt = rrts_pkg::S_DONE;
        end
      end
      rrts_pkg::S_DONE: state_nxt = rrts_pkg::S_IDLE;
      default:          state_nxt = rrts_pkg::S_IDLE;
    endcase
  end

  // datapath control and register next values
  always_comb begin
    tick_nxt     = tick_r;
    cur_nxt      = cur_r;
    used_nxt     = used_r;
    req_nxt      = req_r;
    idx_nxt      = idx_r;
    rot_k_nxt    = rot_k_r;
    diff_nxt     = diff_r;
    woken_nxt    = woken_r;
    status_nxt   = status_r;
    switched_nxt = switched_r;
    rd_idx       = cur_r;
    alu_a        = tick_r;
    alu_b        = '1;
    cmd          = '0;
    cmd.idx      = cur_r;
    cmd.last     = tick_r;

    case (state_r)
      rrts_pkg::S_IDLE: begin
        if (start) begin
          req_nxt      = in_data;
          woken_nxt    = '0;
          switched_nxt = 1'b0;
          status_nxt   = rrts_pkg::ST_OK;
        end
      end
      rrts_pkg::S_ADD: begin
        if (table_full) begin
          status_nxt = rrts_pkg::ST_FULL;
        end else begin
          cmd.idx       = rrts_pkg::slot_t'(used_r);
          cmd.wr_period = 1'b1;
          cmd.period    = req_r.period;
          cmd.wr_last   = 1'b1;
          cmd.wr_sleep  = 1'b1;
          cmd.sleep     = '0;
          cmd.wr_flag   = 1'b1;
          cmd.flag_val  = 1'b0;
          used_nxt      = used_r + rrts_pkg::cnt_t'(1);
        end
      end
      rrts_pkg::S_INC: begin
        // tick - (all ones) is tick + 1 modulo 2^32
        tick_nxt = alu_diff;
        idx_nxt  = '0;
        if (used_r == '0) begin
          status_nxt = rrts_pkg::ST_EMPTY;
        end
      end
      rrts_pkg::S_WAKE: begin
        rd_idx = idx_r;
        alu_a  = rd_sleep;
        alu_b  = rrts_pkg::word_t'(1);
        if (rd_sleeping) begin
          cmd.idx      = idx_r;
          cmd.wr_sleep = 1'b1;
          cmd.sleep    = alu_diff;
          if (alu_zero) begin
            cmd.wr_flag       = 1'b1;
            cmd.flag_val      = 1'b0;
            woken_nxt[idx_r]  = 1'b1;
          end
        end
        idx_nxt = idx_step;
      end
      rrts_pkg::S_DIFF: begin
        alu_a    = tick_r;
        alu_b    = rd_last;
        diff_nxt = alu_diff;
      end
      rrts_pkg::S_CMP: begin
        alu_a     = diff_r;
        alu_b     = rd_period;
        idx_nxt   = cur_r;
        rot_k_nxt = '0;
      end
      rrts_pkg::S_PARK: begin
        idx_nxt   = cur_r;
        rot_k_nxt = '0;
        if (used_r == '0) begin
          status_nxt = rrts_pkg::ST_EMPTY;
        end else if ((req_r.req_type == rrts_pkg::REQ_SLEEP) &&
                     (req_r.sleep_ticks != '0)) begin
          cmd.wr_sleep = 1'b1;
          cmd.sleep    = req_r.sleep_ticks;
          cmd.wr_flag  = 1'b1;
          cmd.flag_val = 1'b1;
        end
      end
      rrts_pkg::S_ROT: begin
        // visit the next used slot in cyclic order, the current one last
        rd_idx    = idx_step;
        idx_nxt   = idx_step;
        rot_k_nxt = rot_k_r + rrts_pkg::cnt_t'(1);
        if (!rd_sleeping) begin
          cur_nxt      = idx_step;
          cmd.idx      = idx_step;
          cmd.wr_last  = 1'b1;
          switched_nxt = 1'b1;
        end else if (rot_last) begin
          status_nxt = rrts_pkg::ST_NOREADY;
        end
      end
      rrts_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rrts_pkg::S_IDLE;
      tick_r     <= '0;
      cur_r      <= '0;
      used_r     <= '0;
      switched_r <= 1'b0;
      status_r   <= rrts_pkg::ST_OK;
      woken_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      tick_r     <= tick_nxt;
      cur_r      <= cur_nxt;
      used_r     <= used_nxt;
      switched_r <= switched_nxt;
      status_r   <= status_nxt;
      woken_r    <= woken_nxt;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    idx_r   <= idx_nxt;
    rot_k_r <= rot_k_nxt;
    diff_r  <= diff_nxt;
  end

  // result beat: low bits of slot index and wake mask
  logic [rrts_pkg::SLOT_W+2:0]      cur_ext;
  logic [rrts_pkg::MAX_THREADS+7:0] woken_ext;

  assign cur_ext   = {3'b000, cur_r};
  assign woken_ext = {8'h00, woken_r};

  assign busy      = (state_r != rrts_pkg::S_IDLE);
  assign out_valid = (state_r == rrts_pkg::S_DONE);

  always_comb begin
    out_data.status         = status_r;
    out_data.switched       = switched_r;
    out_data.running_thread = cur_ext[2:0];
    out_data.woken_mask     = woken_ext[7:0];
    out_data.tick_now       = tick_r;
  end

endmodule
